@@ src/mbr_pkg.sv @@
// ----------------------------------------------------------------------------
// mbr_pkg
// Shared types, constants and helpers of the 2x2 mipmap box reducer.
// ----------------------------------------------------------------------------
package mbr_pkg;

   localparam int MAX_WIDTH   = 4096;
   localparam int MAX_HEIGHT  = 4096;
   localparam int STORE_DEPTH = MAX_WIDTH / 2;
   localparam int IDX_W       = $clog2(STORE_DEPTH);
   localparam int CNT_W       = 12;
   localparam int DIM_W       = 13;
   localparam int PIX_W       = 32;
   localparam int CH_W        = 8;
   localparam int SUM_W       = CH_W + 1;
   localparam int ADDR_W      = 3;
   localparam int DATA_W      = 32;

   localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(256);
   localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(256);
   localparam logic [DIM_W-1:0] DIM_MIN      = DIM_W'(2);

   // register index = paddr[2]
   localparam logic REG_WIDTH  = 1'b0;
   localparam logic REG_HEIGHT = 1'b1;

   typedef struct packed {
      logic [CH_W-1:0]  amax;
      logic [SUM_W-1:0] asum;
      logic [SUM_W-1:0] bsum;
      logic [SUM_W-1:0] gsum;
      logic [SUM_W-1:0] rsum;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic [DIM_W-1:0] width;
      logic [DIM_W-1:0] height;
   } dims_type;

   typedef struct packed {
      logic             col_odd;
      logic             emit;
      logic             store_wr;
      logic             last;
      logic [IDX_W-1:0] idx;
      entry_type        entry;
   } scan_info_type;

   function automatic logic [DIM_W-1:0] even_clamp(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] hi);
      logic [DIM_W-1:0] e;
      e = {v[DIM_W-1:1], 1'b0};
      if (e < DIM_MIN) begin
         e = DIM_MIN;
      end
      if (e > hi) begin
         e = hi;
      end
      return e;
   endfunction

endpackage

@@ src/mbr_stream_if.sv @@
// ----------------------------------------------------------------------------
// mbr_stream_if
// Valid/ready channels for input pixels and reduced pixels.
// ----------------------------------------------------------------------------
interface mbr_req_if;
   logic                      valid;
   logic                      ready;
   logic [mbr_pkg::PIX_W-1:0] pixel_in;

   modport source (output valid, output pixel_in, input ready);
   modport sink (input valid, input pixel_in, output ready);
endinterface

interface mbr_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [mbr_pkg::PIX_W-1:0] pixel_out;
   logic                      last_of_image;

   modport source (output valid, output pixel_out, output last_of_image, input ready);
   modport sink (input valid, input pixel_out, input last_of_image, output ready);
endinterface

@@ src/mbr_csr.sv @@
// ----------------------------------------------------------------------------
// mbr_csr
// APB register file for image width and height; gives clamped even sizes.
// ----------------------------------------------------------------------------
module mbr_csr (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [mbr_pkg::ADDR_W-1:0] csr_paddr,
   input  logic [mbr_pkg::DATA_W-1:0] csr_pwdata,
   output logic [mbr_pkg::DATA_W-1:0] csr_prdata,
   output logic                       csr_pready,
   output mbr_pkg::dims_type          dims
);

   logic [mbr_pkg::DIM_W-1:0] width_ff,  width_in;
   logic [mbr_pkg::DIM_W-1:0] height_ff, height_in;
   logic                      wr;

   assign wr = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (wr) begin
         unique case (csr_paddr[2])
            mbr_pkg::REG_WIDTH:  width_in  = csr_pwdata[mbr_pkg::DIM_W-1:0];
            mbr_pkg::REG_HEIGHT: height_in = csr_pwdata[mbr_pkg::DIM_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= mbr_pkg::WIDTH_RESET;
         height_ff <= mbr_pkg::HEIGHT_RESET;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         mbr_pkg::REG_WIDTH:  csr_prdata = mbr_pkg::DATA_W'(width_ff);
         mbr_pkg::REG_HEIGHT: csr_prdata = mbr_pkg::DATA_W'(height_ff);
         default:             csr_prdata = '0;
      endcase
   end

   assign csr_pready  = 1'b1;
   assign dims.width  = mbr_pkg::even_clamp(width_ff,
                                            mbr_pkg::DIM_W'(mbr_pkg::MAX_WIDTH));
   assign dims.height = mbr_pkg::even_clamp(height_ff,
                                            mbr_pkg::DIM_W'(mbr_pkg::MAX_HEIGHT));

endmodule

@@ src/mbr_line_ram.sv @@
// ----------------------------------------------------------------------------
// mbr_line_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module mbr_line_ram #(
   parameter int DEPTH = 2048,
   parameter int WIDTH = 44
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

@@ src/mbr_scan.sv @@
// ----------------------------------------------------------------------------
// mbr_scan
// Raster position counters, pair hold and horizontal pair sums.
// ----------------------------------------------------------------------------
module mbr_scan (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      accept,
   input  logic [mbr_pkg::PIX_W-1:0] pixel,
   input  mbr_pkg::dims_type         dims,
   output mbr_pkg::scan_info_type    info
);

   logic [mbr_pkg::CNT_W-1:0] col_ff,  col_in;
   logic [mbr_pkg::CNT_W-1:0] row_ff,  row_in;
   logic [mbr_pkg::PIX_W-1:0] hold_ff, hold_in;

   logic                      wrap_c;
   logic [mbr_pkg::CNT_W-1:0] col_now;
   logic [mbr_pkg::DIM_W-1:0] row_pre;
   logic [mbr_pkg::CNT_W-1:0] row_now;
   logic [mbr_pkg::DIM_W-1:0] col_inc;
   logic [mbr_pkg::DIM_W-1:0] row_inc;
   logic [mbr_pkg::CH_W-1:0]  a0, a1;

   always_comb begin
      wrap_c  = {1'b0, col_ff} >= dims.width;
      col_now = wrap_c ? '0 : col_ff;
      row_pre = wrap_c ? {1'b0, row_ff} + 1'b1 : {1'b0, row_ff};
      row_now = (row_pre >= dims.height) ? '0 : row_pre[mbr_pkg::CNT_W-1:0];
      col_inc = {1'b0, col_now} + 1'b1;
      row_inc = {1'b0, row_now} + 1'b1;

      if (col_inc >= dims.width) begin
         col_in = '0;
         row_in = (row_inc >= dims.height) ? '0 : row_inc[mbr_pkg::CNT_W-1:0];
      end else begin
         col_in = col_inc[mbr_pkg::CNT_W-1:0];
         row_in = row_now;
      end

      hold_in = col_now[0] ? hold_ff : pixel;

      a0 = hold_ff[31:24];
      a1 = pixel[31:24];
      info.col_odd    = col_now[0];
      info.emit       = col_now[0] && row_now[0];
      info.store_wr   = col_now[0] && !row_now[0];
      info.last       = (col_inc == dims.width) && (row_inc == dims.height);
      info.idx        = col_now[mbr_pkg::CNT_W-1:1];
      info.entry.rsum = {1'b0, hold_ff[7:0]}   + {1'b0, pixel[7:0]};
      info.entry.gsum = {1'b0, hold_ff[15:8]}  + {1'b0, pixel[15:8]};
      info.entry.bsum = {1'b0, hold_ff[23:16]} + {1'b0, pixel[23:16]};
      info.entry.asum = {1'b0, a0} + {1'b0, a1};
      info.entry.amax = (a0 > a1) ? a0 : a1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         hold_ff <= hold_in;
      end
   end

   a_last_wraps: assert property (@(posedge clock) disable iff (reset)
      accept && info.last |=> col_ff == '0 && row_ff == '0)
      else $error("counters not cleared after last word");

   a_hold_load: assert property (@(posedge clock) disable iff (reset)
      accept && !info.col_odd |=> hold_ff == $past(pixel))
      else $error("pair hold not loaded on even column");

   a_last_emits: assert property (@(posedge clock) disable iff (reset)
      accept && info.last |-> info.emit)
      else $error("last flag on a word that gives no output");

endmodule

@@ src/mbr_combine.sv @@
// ----------------------------------------------------------------------------
// mbr_combine
// Adds stored half-row sums to the current pair and holds the result word.
// ----------------------------------------------------------------------------
module mbr_combine (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      load,
   input  mbr_pkg::entry_type        pair,
   input  logic                      last,
   input  mbr_pkg::entry_type        stored,
   input  logic                      rsp_ready,
   output logic                      advance,
   output logic                      rsp_valid,
   output logic [mbr_pkg::PIX_W-1:0] rsp_pixel,
   output logic                      rsp_last
);

   logic                      s1_valid_ff, s1_valid_in;
   mbr_pkg::entry_type        s1_pair_ff;
   logic                      s1_last_ff;
   logic                      out_valid_ff, out_valid_in;
   logic [mbr_pkg::PIX_W-1:0] out_pixel_ff, out_pixel_in;
   logic                      out_last_ff;

   logic [mbr_pkg::SUM_W:0]   r, g, b, as;
   logic [mbr_pkg::CH_W-1:0]  am;
   logic [mbr_pkg::SUM_W-1:0] ao;

   assign advance = !out_valid_ff || rsp_ready;

   always_comb begin
      s1_valid_in  = advance ? load : s1_valid_ff;
      out_valid_in = advance ? s1_valid_ff : out_valid_ff;

      r  = {1'b0, s1_pair_ff.rsum} + {1'b0, stored.rsum};
      g  = {1'b0, s1_pair_ff.gsum} + {1'b0, stored.gsum};
      b  = {1'b0, s1_pair_ff.bsum} + {1'b0, stored.bsum};
      as = {1'b0, s1_pair_ff.asum} + {1'b0, stored.asum};
      am = (stored.amax > s1_pair_ff.amax) ? stored.amax : s1_pair_ff.amax;
      ao = {1'b0, am} + {1'b0, as[mbr_pkg::SUM_W:2]};
      out_pixel_in = {ao[mbr_pkg::SUM_W-1:1], b[mbr_pkg::SUM_W:2],
                      g[mbr_pkg::SUM_W:2], r[mbr_pkg::SUM_W:2]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && load) begin
         s1_pair_ff <= pair;
         s1_last_ff <= last;
      end
      if (advance && s1_valid_ff) begin
         out_pixel_ff <= out_pixel_in;
         out_last_ff  <= s1_last_ff;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_pixel = out_pixel_ff;
   assign rsp_last  = out_last_ff;

   a_s1_held: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !advance |=> s1_valid_ff)
      else $error("pending word dropped during stall");

   a_s1_moves: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && advance |=> out_valid_ff)
      else $error("pending word not moved to output");

   a_no_load_stalled: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(s1_pair_ff))
      else $error("stage loaded while stalled");

endmodule

@@ src/mipmap_box_reduce_rgba.sv @@
// ----------------------------------------------------------------------------
// mipmap_box_reduce_rgba
// 2x2 box reducer for RGBA8 images, one mip level down.
// ----------------------------------------------------------------------------
// Pixels of one image enter on req_link in raster order, one word per cycle
// unless rsp_link stalls. Each 2x2 block gives one word on rsp_link: RGB are
// the block averages, alpha is (max alpha + mean alpha) / 2. A word leaves on
// the second pixel of each pair on every odd row; last_of_image marks the
// final word of the level. Width and height are set through the csr_ APB port
// (index 0 width at 0x0, index 1 height at 0x4), even values 2..4096. The user
// must see that width and height are changed only while the block is idle;
// the block does not enforce it. Throughput: one input word per cycle while
// rsp_link does not stall. Once the pixel completing a block is accepted, its
// word passes the line RAM read, then the final add into the output register.
// The line RAM holds half-row pair sums (2048 x 44 bits) and is read only
// after the even row wrote it, so it needs no clearing after reset.
// Reset clears the row and column counters and both pipeline valids; the
// configuration returns to 256 x 256.
// When rsp_link stalls, the whole pipe holds and req_link.ready drops in the
// same cycle; no word is lost or repeated.
// ----------------------------------------------------------------------------
module mipmap_box_reduce_rgba (
   input  logic                       clock,
   input  logic                       reset,
   mbr_req_if.sink                    req_link,
   mbr_rsp_if.source                  rsp_link,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [mbr_pkg::ADDR_W-1:0] csr_paddr,
   input  logic [mbr_pkg::DATA_W-1:0] csr_pwdata,
   output logic [mbr_pkg::DATA_W-1:0] csr_prdata,
   output logic                       csr_pready
);

   mbr_pkg::dims_type      dims;
   mbr_pkg::scan_info_type info;
   logic                   accept;
   logic                   advance;
   logic [mbr_pkg::ENTRY_W-1:0] rd_data;

   assign req_link.ready = advance;
   assign accept         = req_link.valid && advance;

   mbr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .dims        (dims)
   );

   mbr_scan u_scan (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .pixel  (req_link.pixel_in),
      .dims   (dims),
      .info   (info)
   );

   mbr_line_ram #(
      .DEPTH (mbr_pkg::STORE_DEPTH),
      .WIDTH (mbr_pkg::ENTRY_W)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (accept && info.store_wr),
      .wr_addr (info.idx),
      .wr_data (info.entry),
      .rd_en   (accept && info.emit),
      .rd_addr (info.idx),
      .rd_data (rd_data)
   );

   mbr_combine u_combine (
      .clock     (clock),
      .reset     (reset),
      .load      (accept && info.emit),
      .pair      (info.entry),
      .last      (info.last),
      .stored    (mbr_pkg::entry_type'(rd_data)),
      .rsp_ready (rsp_link.ready),
      .advance   (advance),
      .rsp_valid (rsp_link.valid),
      .rsp_pixel (rsp_link.pixel_out),
      .rsp_last  (rsp_link.last_of_image)
   );

endmodule
